@@ rtl/sgs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Servo gait sequencer package
// Shared types, codes and pose tables for the servo gait sequencer.
// ----------------------------------------------------------------------------
package sgs_pkg;

  localparam int QueueDepth = 2;
  localparam logic [15:0] ObstacleLimitReset = 16'd150;

  typedef logic [7:0] angle_t;
  typedef angle_t [7:0] pose_t;

  typedef enum logic [1:0] {
    EvCmd  = 2'd0,
    EvTick = 2'd1,
    EvAir  = 2'd2,
    EvNone = 2'd3
  } event_e;

  typedef enum logic [2:0] {
    CmdNone,
    CmdAction,
    CmdCollect,
    CmdAuto,
    CmdManual,
    CmdRest,
    CmdStatus
  } cmd_e;

  typedef enum logic [1:0] {
    PhaseIdle  = 2'd0,
    PhaseLie   = 2'd1,
    PhaseStand = 2'd2
  } phase_e;

  localparam logic [3:0] ActStand   = 4'd0;
  localparam logic [3:0] ActForward = 4'd1;
  localparam logic [3:0] ActBack    = 4'd2;
  localparam logic [3:0] ActLeft    = 4'd3;
  localparam logic [3:0] ActRight   = 4'd4;
  localparam logic [3:0] ActSwing   = 4'd5;
  localparam logic [3:0] ActSquat   = 4'd6;
  localparam logic [3:0] ActLie     = 4'd7;
  localparam logic [3:0] ActLift    = 4'd8;
  localparam logic [3:0] ActWave    = 4'd9;

  localparam int FlagAuto    = 0;
  localparam int FlagCollect = 1;
  localparam int FlagAvoid   = 2;
  localparam int FlagReport  = 3;
  localparam int FlagWave    = 4;
  localparam int FlagLift    = 5;
  localparam int FlagAir     = 6;

  localparam logic [4:0] SwingPeriod = 5'd24;
  localparam logic [4:0] SwingHalf   = 5'd12;
  localparam logic [7:0] SwingSlope  = 8'd5;
  localparam logic [7:0] AngleMax    = 8'd180;

  typedef struct packed {
    logic [1:0]  func;
    logic [39:0] cmd_text;
    logic [15:0] distance_tenths;
    logic        air_level;
  } in_item_t;

  typedef struct packed {
    logic [7:0] hip_a;
    logic [7:0] hip_b;
    logic [7:0] hip_c;
    logic [7:0] hip_d;
    logic [7:0] knee_a;
    logic [7:0] knee_b;
    logic [7:0] knee_c;
    logic [7:0] knee_d;
    logic       pose_update;
    logic [3:0] action_code;
    logic [3:0] mode_flags;
  } out_item_t;

  typedef struct packed {
    event_e      kind;
    cmd_e        cmd;
    logic [3:0]  act_sel;
    logic [15:0] distance;
    logic        air;
  } op_t;

  function automatic pose_t mk_pose(input angle_t a0, input angle_t a1, input angle_t a2,
                                    input angle_t a3, input angle_t a4, input angle_t a5,
                                    input angle_t a6, input angle_t a7);
    pose_t p;
    p[0] = a0;
    p[1] = a1;
    p[2] = a2;
    p[3] = a3;
    p[4] = a4;
    p[5] = a5;
    p[6] = a6;
    p[7] = a7;
    return p;
  endfunction

  localparam pose_t PoseStand = mk_pose(8'd135, 8'd45, 8'd45, 8'd135, 8'd0, 8'd180, 8'd0, 8'd180);
  localparam pose_t PoseLie   = mk_pose(8'd90, 8'd90, 8'd90, 8'd90, 8'd0, 8'd180, 8'd0, 8'd180);
  localparam pose_t PoseSquat = mk_pose(8'd135, 8'd45, 8'd45, 8'd135, 8'd90, 8'd90, 8'd90, 8'd90);
  localparam pose_t PoseLift  = mk_pose(8'd90, 8'd90, 8'd45, 8'd135, 8'd0, 8'd180, 8'd135, 8'd180);
  localparam pose_t PoseWave  = mk_pose(8'd160, 8'd45, 8'd110, 8'd70, 8'd20, 8'd35, 8'd20, 8'd160);

  // Walking and turning poses, selected by direction and step phase.
  function automatic pose_t gait_pose(input logic [1:0] dir, input logic [1:0] ph);
    pose_t p;
    case ({dir, ph})
      4'd0:  p = mk_pose(8'd165, 8'd45, 8'd45, 8'd105, 8'd0, 8'd180, 8'd0, 8'd180);
      4'd1:  p = mk_pose(8'd135, 8'd45, 8'd45, 8'd135, 8'd0, 8'd150, 8'd30, 8'd180);
      4'd2:  p = mk_pose(8'd135, 8'd15, 8'd75, 8'd135, 8'd0, 8'd180, 8'd0, 8'd180);
      4'd3:  p = mk_pose(8'd135, 8'd15, 8'd75, 8'd135, 8'd30, 8'd180, 8'd0, 8'd150);
      4'd4:  p = mk_pose(8'd105, 8'd45, 8'd45, 8'd165, 8'd0, 8'd180, 8'd0, 8'd180);
      4'd5:  p = mk_pose(8'd135, 8'd45, 8'd45, 8'd135, 8'd0, 8'd150, 8'd30, 8'd180);
      4'd6:  p = mk_pose(8'd135, 8'd75, 8'd15, 8'd135, 8'd0, 8'd180, 8'd0, 8'd180);
      4'd7:  p = mk_pose(8'd135, 8'd75, 8'd15, 8'd135, 8'd30, 8'd180, 8'd0, 8'd150);
      4'd8:  p = mk_pose(8'd135, 8'd45, 8'd45, 8'd135, 8'd0, 8'd180, 8'd0, 8'd180);
      4'd9:  p = mk_pose(8'd150, 8'd30, 8'd30, 8'd150, 8'd30, 8'd180, 8'd0, 8'd150);
      4'd10: p = mk_pose(8'd165, 8'd15, 8'd15, 8'd165, 8'd0, 8'd180, 8'd0, 8'd180);
      4'd11: p = mk_pose(8'd165, 8'd15, 8'd15, 8'd165, 8'd0, 8'd150, 8'd30, 8'd180);
      4'd12: p = mk_pose(8'd135, 8'd45, 8'd45, 8'd135, 8'd0, 8'd180, 8'd0, 8'd180);
      4'd13: p = mk_pose(8'd150, 8'd30, 8'd30, 8'd150, 8'd0, 8'd150, 8'd30, 8'd180);
      4'd14: p = mk_pose(8'd165, 8'd15, 8'd15, 8'd165, 8'd0, 8'd180, 8'd0, 8'd180);
      4'd15: p = mk_pose(8'd165, 8'd15, 8'd15, 8'd165, 8'd30, 8'd180, 8'd0, 8'd150);
      default: p = PoseStand;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

@@ rtl/servo_gait_sequencer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Servo gait sequencer core
// Eight-servo pose sequencer for a four-legged robot driven by command,
// gait tick and air sensor events, one result per event.
// ----------------------------------------------------------------------------
// The block takes one request per clock and returns one result per request,
// in order. A request is decoded and written into a small input queue; the
// back end takes one queued request per cycle, updates the gait state and
// writes the result into an output queue, from which it can be popped.
// The sustained rate of one request per cycle is set by the back end,
// which updates the state in the cycle that it takes a request. Both
// queues hold QueueDepth entries, and full or empty stall each side on its
// own. The obstacle limit may be written whenever the block is idle.
module servo_gait_sequencer_core #(
  parameter int QueueDepth = sgs_pkg::QueueDepth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [15:0]       cfg_wdata_i,
  input  wire sgs_pkg::in_item_t in_item_i,
  input  wire logic              push,
  output logic                   full,
  output sgs_pkg::out_item_t     out_item_o,
  output logic                   empty,
  input  wire logic              pop
);

  localparam int OpWidth  = $bits(sgs_pkg::op_t);
  localparam int ResWidth = $bits(sgs_pkg::out_item_t);

  sgs_pkg::op_t       op_in;
  sgs_pkg::op_t       op_head;
  logic [OpWidth-1:0] op_head_bits;
  logic               op_empty;
  logic               op_pop;
  sgs_pkg::out_item_t res;
  logic               res_full;
  logic               res_push;
  logic [ResWidth-1:0] out_bits;

  sgs_front u_front (
    .item_i (in_item_i),
    .op_o   (op_in)
  );

  sgs_fifo #(
    .Width (OpWidth),
    .Depth (QueueDepth)
  ) u_op_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (op_in),
    .full_o  (full),
    .pop_i   (op_pop),
    .rdata_o (op_head_bits),
    .empty_o (op_empty)
  );

  assign op_head = sgs_pkg::op_t'(op_head_bits);

  sgs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .op_i        (op_head),
    .op_empty_i  (op_empty),
    .op_pop_o    (op_pop),
    .res_o       (res),
    .res_full_i  (res_full),
    .res_push_o  (res_push)
  );

  sgs_fifo #(
    .Width (ResWidth),
    .Depth (QueueDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (out_bits),
    .empty_o (empty)
  );

  assign out_item_o = sgs_pkg::out_item_t'(out_bits);

endmodule
`default_nettype wire

@@ rtl/sgs_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Servo gait sequencer front end
// Classifies an incoming event and decodes command text into an operation.
// ----------------------------------------------------------------------------
module sgs_front (
  input  wire sgs_pkg::in_item_t item_i,
  output sgs_pkg::op_t           op_o
);

  logic [39:0] text;

  assign text = item_i.cmd_text;

  always_comb begin
    op_o          = '0;
    op_o.distance = item_i.distance_tenths;
    op_o.air      = item_i.air_level;
    op_o.cmd      = sgs_pkg::CmdNone;
    op_o.act_sel  = sgs_pkg::ActStand;
    case (item_i.func)
      2'd0: op_o.kind = sgs_pkg::EvCmd;
      2'd1: op_o.kind = sgs_pkg::EvTick;
      2'd2: op_o.kind = sgs_pkg::EvAir;
      default: op_o.kind = sgs_pkg::EvNone;
    endcase

    if (text[39:24] == "UP") begin
      op_o.cmd     = sgs_pkg::CmdAction;
      op_o.act_sel = sgs_pkg::ActForward;
    end else if (text[39:8] == "BACK") begin
      op_o.cmd     = sgs_pkg::CmdAction;
      op_o.act_sel = sgs_pkg::ActBack;
    end else if (text[39:8] == "LEFT") begin
      op_o.cmd     = sgs_pkg::CmdAction;
      op_o.act_sel = sgs_pkg::ActLeft;
    end else if (text == "RIGHT") begin
      op_o.cmd     = sgs_pkg::CmdAction;
      op_o.act_sel = sgs_pkg::ActRight;
    end else if (text[39:24] == "YB") begin
      op_o.cmd     = sgs_pkg::CmdAction;
      op_o.act_sel = sgs_pkg::ActSwing;
    end else if (text[39:24] == "ZK") begin
      op_o.cmd     = sgs_pkg::CmdAction;
      op_o.act_sel = sgs_pkg::ActLie;
    end else if (text[39:24] == "ZX") begin
      op_o.cmd     = sgs_pkg::CmdAction;
      op_o.act_sel = sgs_pkg::ActSquat;
    end else if (text[39:24] == "TJ") begin
      op_o.cmd     = sgs_pkg::CmdAction;
      op_o.act_sel = sgs_pkg::ActLift;
    end else if (text[39:24] == "ZS") begin
      op_o.cmd     = sgs_pkg::CmdAction;
      op_o.act_sel = sgs_pkg::ActWave;
    end else if (text[39:24] == "CJ") begin
      op_o.cmd = sgs_pkg::CmdCollect;
    end else if (text[39:8] == "AUTO") begin
      op_o.cmd = sgs_pkg::CmdAuto;
    end else if (text[39:8] == "MANU") begin
      op_o.cmd = sgs_pkg::CmdManual;
    end else if (text[39:8] == "REST") begin
      op_o.cmd = sgs_pkg::CmdRest;
    end else if (text[39:8] == "STAT") begin
      op_o.cmd = sgs_pkg::CmdStatus;
    end
  end

endmodule
`default_nettype wire

@@ rtl/sgs_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Servo gait sequencer queue
// Small first-in first-out queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module sgs_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d;
  logic [PtrW-1:0]  rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

@@ rtl/sgs_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Servo gait sequencer back end
// Holds gait state; turns one operation per cycle to a result unless stalled.
// ----------------------------------------------------------------------------
module sgs_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [15:0]     cfg_wdata_i,
  input  wire sgs_pkg::op_t    op_i,
  input  wire logic            op_empty_i,
  output logic                 op_pop_o,
  output sgs_pkg::out_item_t   res_o,
  input  wire logic            res_full_i,
  output logic                 res_push_o
);

  logic [15:0]     limit_q;
  logic [3:0]      action_q, action_d;
  logic [15:0]     step_q, step_d;
  logic [4:0]      mod_q, mod_d;
  logic [3:0]      target_q, target_d;
  sgs_pkg::phase_e phase_q, phase_d;
  logic [6:0]      flags_q, flags_d;
  logic [15:0]     dist_q, dist_d;
  sgs_pkg::pose_t  pose_q, pose_d;
  logic [3:0]      cur;
  logic [4:0]      swing_pos;
  logic [7:0]      knee;
  logic            fire;

  assign fire       = !op_empty_i && !res_full_i;
  assign op_pop_o   = fire;
  assign res_push_o = fire;

  always_comb begin
    action_d  = action_q;
    step_d    = step_q;
    mod_d     = mod_q;
    target_d  = target_q;
    phase_d   = phase_q;
    flags_d   = flags_q;
    dist_d    = dist_q;
    pose_d    = pose_q;
    cur       = action_q;
    swing_pos = '0;
    knee      = '0;
    flags_d[sgs_pkg::FlagReport] = 1'b0;

    case (op_i.kind)
      sgs_pkg::EvCmd: begin
        case (op_i.cmd)
          sgs_pkg::CmdAction: begin
            flags_d[sgs_pkg::FlagAuto]  = 1'b0;
            flags_d[sgs_pkg::FlagAvoid] = 1'b0;
            if (op_i.act_sel != sgs_pkg::ActLie) begin
              flags_d[sgs_pkg::FlagCollect] = 1'b0;
            end
            if (action_q != sgs_pkg::ActStand && op_i.act_sel != action_q &&
                op_i.act_sel != sgs_pkg::ActLie) begin
              target_d = op_i.act_sel;
              phase_d  = sgs_pkg::PhaseLie;
            end else begin
              action_d = op_i.act_sel;
              step_d   = '0;
              mod_d    = '0;
            end
          end
          sgs_pkg::CmdCollect: begin
            flags_d[sgs_pkg::FlagAuto]    = 1'b0;
            flags_d[sgs_pkg::FlagAvoid]   = 1'b0;
            flags_d[sgs_pkg::FlagCollect] = 1'b1;
            action_d = sgs_pkg::ActLie;
            step_d   = '0;
            mod_d    = '0;
          end
          sgs_pkg::CmdAuto: begin
            flags_d[sgs_pkg::FlagAuto]    = 1'b1;
            flags_d[sgs_pkg::FlagCollect] = 1'b0;
            target_d = sgs_pkg::ActForward;
            phase_d  = sgs_pkg::PhaseLie;
            step_d   = '0;
            mod_d    = '0;
          end
          sgs_pkg::CmdManual: begin
            flags_d[sgs_pkg::FlagAuto]    = 1'b0;
            flags_d[sgs_pkg::FlagAvoid]   = 1'b0;
            flags_d[sgs_pkg::FlagCollect] = 1'b0;
            target_d = sgs_pkg::ActStand;
            phase_d  = sgs_pkg::PhaseIdle;
            step_d   = '0;
            mod_d    = '0;
            action_d = sgs_pkg::ActLie;
          end
          sgs_pkg::CmdRest: begin
            flags_d[sgs_pkg::FlagAuto]    = 1'b0;
            flags_d[sgs_pkg::FlagAvoid]   = 1'b0;
            flags_d[sgs_pkg::FlagCollect] = 1'b0;
            flags_d[sgs_pkg::FlagWave]    = 1'b0;
            flags_d[sgs_pkg::FlagLift]    = 1'b0;
            target_d = sgs_pkg::ActStand;
            phase_d  = sgs_pkg::PhaseIdle;
            step_d   = '0;
            mod_d    = '0;
            action_d = sgs_pkg::ActStand;
            pose_d   = sgs_pkg::PoseStand;
          end
          sgs_pkg::CmdStatus: begin
            flags_d[sgs_pkg::FlagReport] = 1'b1;
          end
          default: ;
        endcase
      end

      sgs_pkg::EvTick: begin
        if (op_i.distance != '0) begin
          dist_d = op_i.distance;
        end
        step_d = step_q + 16'd1;
        if (step_q == '1 || mod_q == sgs_pkg::SwingPeriod - 5'd1) begin
          mod_d = '0;
        end else begin
          mod_d = mod_q + 5'd1;
        end

        case (phase_q)
          sgs_pkg::PhaseLie: begin
            pose_d  = sgs_pkg::PoseLie;
            phase_d = sgs_pkg::PhaseStand;
          end
          sgs_pkg::PhaseStand: begin
            pose_d   = sgs_pkg::PoseStand;
            phase_d  = sgs_pkg::PhaseIdle;
            action_d = target_q;
            step_d   = '0;
            mod_d    = '0;
          end
          sgs_pkg::PhaseIdle: begin
            if (action_q == sgs_pkg::ActForward && dist_d != '0 && dist_d < limit_q) begin
              flags_d[sgs_pkg::FlagAvoid] = 1'b1;
              cur = sgs_pkg::ActLeft;
            end else begin
              flags_d[sgs_pkg::FlagAvoid] = 1'b0;
            end
          end
          default: ;
        endcase

        case (cur)
          sgs_pkg::ActForward, sgs_pkg::ActBack, sgs_pkg::ActLeft, sgs_pkg::ActRight: begin
            pose_d = sgs_pkg::gait_pose(2'(cur - 4'd1), step_d[1:0]);
          end
          sgs_pkg::ActSwing: begin
            swing_pos = (mod_d < sgs_pkg::SwingHalf) ? mod_d : 5'(sgs_pkg::SwingPeriod - mod_d);
            knee      = 8'({3'b000, swing_pos} * sgs_pkg::SwingSlope);
            pose_d    = sgs_pkg::PoseStand;
            pose_d[4] = knee;
            pose_d[5] = sgs_pkg::AngleMax - knee;
            pose_d[6] = knee;
            pose_d[7] = sgs_pkg::AngleMax - knee;
          end
          sgs_pkg::ActSquat: pose_d = sgs_pkg::PoseSquat;
          sgs_pkg::ActLie:   pose_d = sgs_pkg::PoseLie;
          sgs_pkg::ActLift: begin
            pose_d = flags_q[sgs_pkg::FlagLift] ? sgs_pkg::PoseStand : sgs_pkg::PoseLift;
            flags_d[sgs_pkg::FlagLift] = !flags_q[sgs_pkg::FlagLift];
            action_d = sgs_pkg::ActStand;
          end
          sgs_pkg::ActWave: begin
            pose_d = flags_q[sgs_pkg::FlagWave] ? sgs_pkg::PoseStand : sgs_pkg::PoseWave;
            flags_d[sgs_pkg::FlagWave] = !flags_q[sgs_pkg::FlagWave];
            action_d = sgs_pkg::ActStand;
          end
          default: ;
        endcase
      end

      sgs_pkg::EvAir: begin
        if (op_i.air) begin
          if (!flags_q[sgs_pkg::FlagAir] && action_q != sgs_pkg::ActSwing) begin
            flags_d[sgs_pkg::FlagAir]  = 1'b1;
            flags_d[sgs_pkg::FlagAuto] = 1'b0;
            action_d = sgs_pkg::ActSwing;
            step_d   = '0;
            mod_d    = '0;
          end
        end else if (flags_q[sgs_pkg::FlagAir]) begin
          flags_d[sgs_pkg::FlagAir] = 1'b0;
          action_d = sgs_pkg::ActLie;
          step_d   = '0;
          mod_d    = '0;
        end
      end

      default: ;
    endcase
  end

  always_comb begin
    res_o.hip_a       = pose_d[0];
    res_o.hip_b       = pose_d[1];
    res_o.hip_c       = pose_d[2];
    res_o.hip_d       = pose_d[3];
    res_o.knee_a      = pose_d[4];
    res_o.knee_b      = pose_d[5];
    res_o.knee_c      = pose_d[6];
    res_o.knee_d      = pose_d[7];
    res_o.pose_update = (op_i.kind == sgs_pkg::EvTick);
    res_o.action_code = action_d;
    res_o.mode_flags  = flags_d[3:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= sgs_pkg::ObstacleLimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      action_q <= sgs_pkg::ActStand;
      step_q   <= '0;
      mod_q    <= '0;
      target_q <= sgs_pkg::ActStand;
      phase_q  <= sgs_pkg::PhaseIdle;
      flags_q  <= '0;
      dist_q   <= '0;
      pose_q   <= sgs_pkg::PoseLie;
    end else if (fire) begin
      action_q <= action_d;
      step_q   <= step_d;
      mod_q    <= mod_d;
      target_q <= target_d;
      phase_q  <= phase_d;
      flags_q  <= flags_d;
      dist_q   <= dist_d;
      pose_q   <= pose_d;
    end
  end

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo gait sequencer core testbench
// Drives command, gait tick and air sensor requests through the input queue,
// predicts every pose result with an independent gait model, and checks each
// popped result field by field under varying idling and obstacle limits.
// ----------------------------------------------------------------------------
module tb_top;
  import sgs_pkg::*;

  typedef logic [63:0] stance_t;

  typedef enum logic [1:0] {
    JobEvent,
    JobLimit,
    JobDrain,
    JobPace
  } job_kind_e;

  typedef struct packed {
    job_kind_e   kind;
    in_item_t    ev;
    logic [15:0] limit;
    logic [6:0]  send_pct;
    logic [6:0]  recv_pct;
  } job_t;

  localparam stance_t StanceStand =
    {8'd135, 8'd45, 8'd45, 8'd135, 8'd0, 8'd180, 8'd0, 8'd180};
  localparam stance_t StanceLie =
    {8'd90, 8'd90, 8'd90, 8'd90, 8'd0, 8'd180, 8'd0, 8'd180};
  localparam stance_t StanceSquat =
    {8'd135, 8'd45, 8'd45, 8'd135, 8'd90, 8'd90, 8'd90, 8'd90};
  localparam stance_t StanceLift =
    {8'd90, 8'd90, 8'd45, 8'd135, 8'd0, 8'd180, 8'd135, 8'd180};
  localparam stance_t StanceWave =
    {8'd160, 8'd45, 8'd110, 8'd70, 8'd20, 8'd35, 8'd20, 8'd160};
  localparam logic [15:0] TurnLimitReset = 16'd150;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  in_item_t   in_item_i = '0;
  logic       push = 1'b0;
  logic       full;
  out_item_t  out_item_o;
  logic       empty;
  logic       pop = 1'b0;

  job_t      jobs[$];
  out_item_t due_poses[$];

  int send_idle = 0;
  int recv_idle = 0;
  int events_sent = 0;
  int ticks_sent = 0;
  int poses_checked = 0;
  int limit_writes = 0;
  int mismatches = 0;

  logic [15:0]       turn_limit = TurnLimitReset;
  logic [3:0]        gait_act = ActStand;
  logic [15:0]       gait_steps = '0;
  logic [3:0]        queued_act = ActStand;
  sgs_pkg::phase_e   swap_phase = PhaseIdle;
  logic [6:0]        mode_bits = '0;
  logic [15:0]       range_tenths = '0;
  stance_t           stance = StanceLie;

  servo_gait_sequencer_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_item_i  (in_item_i),
    .push       (push),
    .full       (full),
    .out_item_o (out_item_o),
    .empty      (empty),
    .pop        (pop)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic bit starts_with(input logic [39:0] text, input string word);
    for (int i = 0; i < word.len(); i++) begin
      if (text[39 - 8 * i -: 8] != word[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [39:0] spell(input string word, input bit tail);
    logic [39:0] text;
    for (int i = 0; i < 5; i++) begin
      if (i < word.len()) text[39 - 8 * i -: 8] = word[i];
      else text[39 - 8 * i -: 8] = tail ? 8'($urandom_range(255)) : 8'd0;
    end
    return text;
  endfunction

  function automatic stance_t walk_stance(input logic [3:0] mv, input logic [1:0] ph);
    logic [3:0] dir;
    stance_t s;
    dir = mv - 4'd1;
    case ({dir[1:0], ph})
      4'd0:  s = {8'd165, 8'd45, 8'd45, 8'd105, 8'd0, 8'd180, 8'd0, 8'd180};
      4'd1:  s = {8'd135, 8'd45, 8'd45, 8'd135, 8'd0, 8'd150, 8'd30, 8'd180};
      4'd2:  s = {8'd135, 8'd15, 8'd75, 8'd135, 8'd0, 8'd180, 8'd0, 8'd180};
      4'd3:  s = {8'd135, 8'd15, 8'd75, 8'd135, 8'd30, 8'd180, 8'd0, 8'd150};
      4'd4:  s = {8'd105, 8'd45, 8'd45, 8'd165, 8'd0, 8'd180, 8'd0, 8'd180};
      4'd5:  s = {8'd135, 8'd45, 8'd45, 8'd135, 8'd0, 8'd150, 8'd30, 8'd180};
      4'd6:  s = {8'd135, 8'd75, 8'd15, 8'd135, 8'd0, 8'd180, 8'd0, 8'd180};
      4'd7:  s = {8'd135, 8'd75, 8'd15, 8'd135, 8'd30, 8'd180, 8'd0, 8'd150};
      4'd8:  s = {8'd135, 8'd45, 8'd45, 8'd135, 8'd0, 8'd180, 8'd0, 8'd180};
      4'd9:  s = {8'd150, 8'd30, 8'd30, 8'd150, 8'd30, 8'd180, 8'd0, 8'd150};
      4'd10: s = {8'd165, 8'd15, 8'd15, 8'd165, 8'd0, 8'd180, 8'd0, 8'd180};
      4'd11: s = {8'd165, 8'd15, 8'd15, 8'd165, 8'd0, 8'd150, 8'd30, 8'd180};
      4'd12: s = {8'd135, 8'd45, 8'd45, 8'd135, 8'd0, 8'd180, 8'd0, 8'd180};
      4'd13: s = {8'd150, 8'd30, 8'd30, 8'd150, 8'd0, 8'd150, 8'd30, 8'd180};
      4'd14: s = {8'd165, 8'd15, 8'd15, 8'd165, 8'd0, 8'd180, 8'd0, 8'd180};
      4'd15: s = {8'd165, 8'd15, 8'd15, 8'd165, 8'd30, 8'd180, 8'd0, 8'd150};
      default: s = StanceStand;
    endcase
    return s;
  endfunction

  function automatic string pose_text(input out_item_t r);
    return $sformatf("pose %0d,%0d,%0d,%0d,%0d,%0d,%0d,%0d update %0d action %0d flags %h",
                     r.hip_a, r.hip_b, r.hip_c, r.hip_d, r.knee_a, r.knee_b, r.knee_c,
                     r.knee_d, r.pose_update, r.action_code, r.mode_flags);
  endfunction

  task automatic note_failure(input string detail);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH %s", detail);
  endtask

  task automatic sequence_event(input in_item_t ev);
    logic [3:0] cue;
    logic [3:0] cur;
    logic [4:0] m24;
    logic [7:0] k;
    cue = ActStand;
    mode_bits[FlagReport] = 1'b0;
    case (ev.func)
      EvCmd: begin
        if (starts_with(ev.cmd_text, "UP")) cue = ActForward;
        else if (starts_with(ev.cmd_text, "BACK")) cue = ActBack;
        else if (starts_with(ev.cmd_text, "LEFT")) cue = ActLeft;
        else if (starts_with(ev.cmd_text, "RIGHT")) cue = ActRight;
        else if (starts_with(ev.cmd_text, "YB")) cue = ActSwing;
        else if (starts_with(ev.cmd_text, "ZK")) cue = ActLie;
        else if (starts_with(ev.cmd_text, "ZX")) cue = ActSquat;
        else if (starts_with(ev.cmd_text, "TJ")) cue = ActLift;
        else if (starts_with(ev.cmd_text, "ZS")) cue = ActWave;
        else if (starts_with(ev.cmd_text, "CJ")) begin
          mode_bits[FlagAuto] = 1'b0;
          mode_bits[FlagAvoid] = 1'b0;
          mode_bits[FlagCollect] = 1'b1;
          gait_act = ActLie;
          gait_steps = '0;
        end else if (starts_with(ev.cmd_text, "AUTO")) begin
          mode_bits[FlagAuto] = 1'b1;
          mode_bits[FlagCollect] = 1'b0;
          queued_act = ActForward;
          swap_phase = PhaseLie;
          gait_steps = '0;
        end else if (starts_with(ev.cmd_text, "MANU")) begin
          mode_bits[FlagAuto] = 1'b0;
          mode_bits[FlagAvoid] = 1'b0;
          mode_bits[FlagCollect] = 1'b0;
          queued_act = ActStand;
          swap_phase = PhaseIdle;
          gait_steps = '0;
          gait_act = ActLie;
        end else if (starts_with(ev.cmd_text, "REST")) begin
          mode_bits[FlagAuto] = 1'b0;
          mode_bits[FlagAvoid] = 1'b0;
          mode_bits[FlagCollect] = 1'b0;
          mode_bits[FlagWave] = 1'b0;
          mode_bits[FlagLift] = 1'b0;
          queued_act = ActStand;
          swap_phase = PhaseIdle;
          gait_steps = '0;
          gait_act = ActStand;
          stance = StanceStand;
        end else if (starts_with(ev.cmd_text, "STAT")) begin
          mode_bits[FlagReport] = 1'b1;
        end
        if (cue != ActStand) begin
          mode_bits[FlagAuto] = 1'b0;
          mode_bits[FlagAvoid] = 1'b0;
          if (cue != ActLie) mode_bits[FlagCollect] = 1'b0;
          if (gait_act != ActStand && cue != gait_act && cue != ActLie) begin
            queued_act = cue;
            swap_phase = PhaseLie;
          end else begin
            gait_act = cue;
            gait_steps = '0;
          end
        end
      end
      EvTick: begin
        if (ev.distance_tenths != 16'd0) range_tenths = ev.distance_tenths;
        gait_steps = gait_steps + 16'd1;
        cur = gait_act;
        if (swap_phase != PhaseIdle) begin
          if (swap_phase == PhaseLie) begin
            stance = StanceLie;
            swap_phase = PhaseStand;
          end else if (swap_phase == PhaseStand) begin
            stance = StanceStand;
            swap_phase = PhaseIdle;
            gait_act = queued_act;
            gait_steps = '0;
          end
        end else if (gait_act == ActForward && range_tenths != 16'd0 &&
                     range_tenths < turn_limit) begin
          mode_bits[FlagAvoid] = 1'b1;
          cur = ActLeft;
        end else begin
          mode_bits[FlagAvoid] = 1'b0;
        end
        if (cur >= ActForward && cur <= ActRight) begin
          stance = walk_stance(cur, gait_steps[1:0]);
        end else if (cur == ActSwing) begin
          m24 = 5'(gait_steps % 16'd24);
          k = (m24 < 5'd12) ? 8'(m24) * 8'd5 : 8'(5'd24 - m24) * 8'd5;
          stance = {StanceStand[63:32], k, 8'd180 - k, k, 8'd180 - k};
        end else if (cur == ActSquat) begin
          stance = StanceSquat;
        end else if (cur == ActLie) begin
          stance = StanceLie;
        end else if (cur == ActLift) begin
          stance = mode_bits[FlagLift] ? StanceStand : StanceLift;
          mode_bits[FlagLift] = ~mode_bits[FlagLift];
          gait_act = ActStand;
        end else if (cur == ActWave) begin
          stance = mode_bits[FlagWave] ? StanceStand : StanceWave;
          mode_bits[FlagWave] = ~mode_bits[FlagWave];
          gait_act = ActStand;
        end
      end
      EvAir: begin
        if (ev.air_level) begin
          if (!mode_bits[FlagAir] && gait_act != ActSwing) begin
            mode_bits[FlagAir] = 1'b1;
            mode_bits[FlagAuto] = 1'b0;
            gait_act = ActSwing;
            gait_steps = '0;
          end
        end else if (mode_bits[FlagAir]) begin
          mode_bits[FlagAir] = 1'b0;
          gait_act = ActLie;
          gait_steps = '0;
        end
      end
      default: ;
    endcase
    due_poses.push_back({stance, ev.func == EvTick, gait_act, mode_bits[3:0]});
  endtask

  always @(posedge clk_i) begin : drive
    bit        waiting;
    bit        hold;
    logic      next_push;
    logic      next_we;
    logic [15:0] next_wdata;
    in_item_t  next_ev;
    job_t      job;
    if (rst_ni) begin
      waiting = push;
      if (push && !full) begin
        sequence_event(in_item_i);
        events_sent++;
        if (in_item_i.func == EvTick) ticks_sent++;
        waiting = 1'b0;
      end
      next_push = waiting;
      next_ev = in_item_i;
      next_we = 1'b0;
      next_wdata = cfg_wdata_i;
      hold = waiting;
      while (!hold && jobs.size() != 0) begin
        job = jobs[0];
        case (job.kind)
          JobPace: begin
            send_idle = job.send_pct;
            recv_idle = job.recv_pct;
            job = jobs.pop_front();
          end
          JobDrain: begin
            if (due_poses.size() == 0) job = jobs.pop_front();
            else hold = 1'b1;
          end
          JobLimit: begin
            if (due_poses.size() == 0) begin
              next_we = 1'b1;
              next_wdata = job.limit;
              turn_limit = job.limit;
              limit_writes++;
              job = jobs.pop_front();
            end
            hold = 1'b1;
          end
          default: begin
            if ($urandom_range(99) >= send_idle) begin
              next_push = 1'b1;
              next_ev = job.ev;
              job = jobs.pop_front();
            end
            hold = 1'b1;
          end
        endcase
      end
      push <= next_push;
      in_item_i <= next_ev;
      cfg_we_i <= next_we;
      cfg_wdata_i <= next_wdata;
    end
  end

  always @(posedge clk_i) begin : watch
    out_item_t want;
    string     diffs;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (due_poses.size() == 0) begin
          note_failure({"result with nothing outstanding: got ", pose_text(out_item_o)});
        end else begin
          want = due_poses.pop_front();
          poses_checked++;
          diffs = "";
          for (int i = 0; i < 8; i++) begin
            if (out_item_o[$bits(out_item_t) - 1 - 8 * i -: 8] !==
                want[$bits(out_item_t) - 1 - 8 * i -: 8])
              diffs = {diffs, $sformatf(" servo%0d", i + 1)};
          end
          if (out_item_o.pose_update !== want.pose_update) diffs = {diffs, " pose_update"};
          if (out_item_o.action_code !== want.action_code)
            diffs = {diffs, " action_code"};
          if (out_item_o.mode_flags !== want.mode_flags) diffs = {diffs, " mode_flags"};
          if (diffs != "")
            note_failure({"on", diffs, ": expected ", pose_text(want), ", got ",
                          pose_text(out_item_o)});
        end
      end
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic plan_event(input in_item_t ev);
    job_t job;
    job = '0;
    job.kind = JobEvent;
    job.ev = ev;
    jobs.push_back(job);
  endtask

  task automatic plan_ctrl(input job_kind_e kind, input logic [15:0] limit,
                           input int send_pct, input int recv_pct);
    job_t job;
    job = '0;
    job.kind = kind;
    job.limit = limit;
    job.send_pct = 7'(send_pct);
    job.recv_pct = 7'(recv_pct);
    jobs.push_back(job);
  endtask

  function automatic string vocab(input int idx);
    case (idx)
      0: return "UP";
      1: return "BACK";
      2: return "LEFT";
      3: return "RIGHT";
      4: return "YB";
      5: return "ZK";
      6: return "ZX";
      7: return "TJ";
      8: return "ZS";
      9: return "CJ";
      10: return "AUTO";
      11: return "MANU";
      12: return "REST";
      default: return "STAT";
    endcase
  endfunction

  function automatic in_item_t noise_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(in_item_t) - 1:0];
  endfunction

  task automatic plan_random(input int count);
    in_item_t ev;
    int n;
    int burst;
    int roll;
    n = 0;
    while (n < count) begin
      ev = noise_item();
      ev.func = EvCmd;
      if ($urandom_range(9) < 8)
        ev.cmd_text = spell(vocab($urandom_range(13)), 1'($urandom_range(1)));
      plan_event(ev);
      n++;
      burst = $urandom_range(20);
      for (int j = 0; j < burst; j++) begin
        ev = noise_item();
        roll = $urandom_range(99);
        if (roll < 80) begin
          ev.func = EvTick;
          roll = $urandom_range(9);
          if (roll < 2) ev.distance_tenths = 16'd0;
          else if (roll < 6) ev.distance_tenths = 16'($urandom_range(1, 400));
          else if (roll == 6) ev.distance_tenths = 16'hFFFF;
        end else if (roll < 92) begin
          ev.func = EvAir;
        end
        plan_event(ev);
        n++;
      end
    end
  endtask

  initial begin
    int guard;
    plan_ctrl(JobPace, '0, 29, 60);
    plan_ctrl(JobLimit, 16'hFFFF, 0, 0);
    plan_event({EvNone, {40{1'b1}}, 16'hFFFF, 1'b1});
    plan_event({EvTick, 40'd0, 16'd0, 1'b0});
    plan_event({EvCmd, spell("STAT", 0), 16'd0, 1'b0});
    plan_event({EvCmd, spell("UP", 0), 16'd0, 1'b0});
    plan_event({EvTick, 40'd0, 16'd100, 1'b0});
    plan_event({EvTick, 40'd0, 16'd0, 1'b0});
    plan_event({EvCmd, spell("BACK", 0), 16'd0, 1'b0});
    plan_event({EvTick, 40'd0, 16'd0, 1'b0});
    plan_event({EvTick, 40'd0, 16'd0, 1'b0});
    plan_event({EvCmd, spell("RIGHT", 0), 16'd0, 1'b0});
    plan_event({EvCmd, spell("LEFT", 0), 16'd0, 1'b0});
    plan_event({EvTick, 40'd0, 16'd0, 1'b0});
    plan_event({EvTick, 40'd0, 16'd0, 1'b0});
    plan_event({EvCmd, spell("REST", 0), 16'd0, 1'b0});
    plan_event({EvCmd, spell("AUTO", 0), 16'd0, 1'b0});
    plan_event({EvTick, 40'd0, 16'd0, 1'b0});
    plan_event({EvCmd, spell("TJ", 0), 16'd0, 1'b0});
    plan_event({EvTick, 40'd0, 16'd0, 1'b0});
    plan_event({EvCmd, spell("ZS", 0), 16'd0, 1'b0});
    plan_event({EvTick, 40'd0, 16'd0, 1'b0});
    plan_event({EvAir, 40'd0, 16'd0, 1'b1});
    plan_event({EvTick, 40'd0, 16'hFFFF, 1'b0});
    plan_event({EvAir, 40'd0, 16'd0, 1'b0});
    plan_event({EvCmd, spell("CJ", 0), 16'd0, 1'b0});
    plan_event({EvCmd, spell("ZX", 0), 16'd0, 1'b0});
    plan_event({EvCmd, spell("MANU", 0), 16'd0, 1'b0});
    plan_event({EvCmd, spell("ZK", 0), 16'd0, 1'b0});
    plan_event({EvCmd, spell("YB", 0), 16'd0, 1'b0});
    plan_event({EvCmd, 40'd0, 16'd0, 1'b0});
    plan_ctrl(JobDrain, '0, 0, 0);
    plan_ctrl(JobLimit, 16'd0, 0, 0);
    plan_random(180);
    plan_ctrl(JobPace, '0, 60, 29);
    plan_ctrl(JobLimit, 16'd300, 0, 0);
    plan_random(90);
    plan_ctrl(JobDrain, '0, 0, 0);
    plan_random(90);
    plan_ctrl(JobPace, '0, 0, 0);
    plan_ctrl(JobLimit, 16'($urandom_range(1, 2000)), 0, 0);
    plan_random(100);
    plan_ctrl(JobLimit, 16'd1, 0, 0);
    plan_random(90);

    while (jobs.size() != 0 || push) @(posedge clk_i);
    for (guard = 0; guard < 100000 && due_poses.size() != 0; guard++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (due_poses.size() != 0) begin
      mismatches += due_poses.size();
      $display("%0d expected poses were never delivered", due_poses.size());
    end
    $display("Sent %0d requests (%0d gait ticks) across %0d obstacle limit settings.",
             events_sent, ticks_sent, limit_writes);
    $display("Checked %0d poses, %0d mismatches.", poses_checked, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
